// File: rtl/stl_pkg.sv
`timescale 1ns / 1ps

package stl_pkg;

	localparam int MAX_LINE_BYTES  = 4096;
	localparam int LINE_COUNT_BITS = 20;
	localparam int COL_W  = $clog2(MAX_LINE_BYTES);
	localparam int LEN_W  = COL_W + 1;
	localparam int LINE_W = LINE_COUNT_BITS;
	localparam int TYPE_W = 6;
	localparam int NUM_KW = 24;
	localparam int KW_MAX = 9;

	localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
	localparam logic [COL_W-1:0]  COL_MAX  = COL_W'(MAX_LINE_BYTES - 1);
	localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_LINE_BYTES);

	localparam logic [7:0] DIGIT_LO = 8'd48;
	localparam logic [7:0] DIGIT_HI = 8'd57;

	localparam logic [TYPE_W-1:0] TOK_NEQ       = 6'd7;
	localparam logic [TYPE_W-1:0] TOK_IDENT     = 6'd14;
	localparam logic [TYPE_W-1:0] TOK_STRING    = 6'd15;
	localparam logic [TYPE_W-1:0] TOK_NUMBER    = 6'd16;
	localparam logic [TYPE_W-1:0] TOK_SEMICOLON = 6'd17;
	localparam logic [TYPE_W-1:0] TOK_COLON     = 6'd18;
	localparam logic [TYPE_W-1:0] TOK_NOT       = 6'd21;
	localparam logic [TYPE_W-1:0] TOK_LBRACE    = 6'd23;
	localparam logic [TYPE_W-1:0] TOK_RBRACE    = 6'd24;
	localparam logic [TYPE_W-1:0] TOK_LPAREN    = 6'd25;
	localparam logic [TYPE_W-1:0] TOK_RPAREN    = 6'd26;
	localparam logic [TYPE_W-1:0] TOK_LBRACKET  = 6'd27;
	localparam logic [TYPE_W-1:0] TOK_RBRACKET  = 6'd28;
	localparam logic [TYPE_W-1:0] TOK_COMMA     = 6'd34;
	localparam logic [TYPE_W-1:0] TOK_DOT       = 6'd35;
	localparam logic [TYPE_W-1:0] TOK_CHAR      = 6'd39;
	localparam logic [TYPE_W-1:0] TOK_NONE      = 6'd0;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_WORD  = 3'd1,
		MODE_BANG  = 3'd2,
		MODE_QUOTE = 3'd3,
		MODE_ESC   = 3'd4
	} mode_t;

	// keyword text, right justified: first char in the highest used byte
	localparam logic [8*KW_MAX-1:0] KW_TEXT [NUM_KW] = '{
		72'("="), 72'("=="), 72'("<"), 72'(">"), 72'("<="), 72'(">="),
		72'("||"), 72'("&&"), 72'("+"), 72'("-"), 72'("*"), 72'("/"), 72'("%"),
		72'("loop"), 72'("if"), 72'("let"), 72'({"print", "_str"}),
		72'({"print", "_val"}),
		72'("def"), 72'("return"), 72'("struct"), 72'("true"), 72'("false"),
		72'({"read", "_char"})
	};
	localparam logic [3:0] KW_LEN [NUM_KW] = '{
		4'd1, 4'd2, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1,
		4'd1, 4'd4, 4'd2, 4'd3, 4'd9, 4'd9, 4'd3, 4'd6, 4'd6, 4'd4, 4'd5, 4'd9
	};
	localparam logic [TYPE_W-1:0] KW_TYPE [NUM_KW] = '{
		6'd5, 6'd6, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13,
		6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd19, 6'd20, 6'd22,
		6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd36, 6'd37, 6'd38
	};

	typedef struct packed {
		logic [TYPE_W-1:0] token_type;
		logic [LINE_W-1:0] line_number;
		logic [COL_W-1:0]  start_column;
		logic [LEN_W-1:0]  token_length;
		logic              last_of_run;
	} tok_t;

	typedef struct packed {
		logic v0;
		logic v1;
		tok_t r0;
		tok_t r1;
	} tok_pair_t;

	function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [3:0] pos);
		logic [3:0] sh;
		logic [7:0] ch;
		sh = 4'd0;
		ch = 8'h00;
		if (pos < KW_LEN[k]) begin
			sh = KW_LEN[k] - 4'd1 - pos;
			ch = KW_TEXT[k][{sh, 3'b000} +: 8];
		end
		return ch;
	endfunction

	function automatic logic [TYPE_W-1:0] mark_type(input logic [7:0] c);
		logic [TYPE_W-1:0] t;
		case (c)
			8'h3B:   t = TOK_SEMICOLON;
			8'h3A:   t = TOK_COLON;
			8'h7B:   t = TOK_LBRACE;
			8'h7D:   t = TOK_RBRACE;
			8'h28:   t = TOK_LPAREN;
			8'h29:   t = TOK_RPAREN;
			8'h5B:   t = TOK_LBRACKET;
			8'h5D:   t = TOK_RBRACKET;
			8'h2C:   t = TOK_COMMA;
			8'h2E:   t = TOK_DOT;
			8'h21:   t = TOK_NOT;
			default: t = TOK_NONE;
		endcase
		return t;
	endfunction

endpackage

// File: rtl/stl_core.sv
`timescale 1ns / 1ps

module stl_core import stl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       func,
	input  logic [7:0] char_code,
	output tok_pair_t  toks
);

	mode_t              mode_q, mode_n;
	logic               qd_q, qd_n;
	logic [COL_W-1:0]   col_q, col_n;
	logic [COL_W-1:0]   start_q, start_n;
	logic [LEN_W-1:0]   tb_q, tb_n;
	logic [LINE_W-1:0]  lines_q, lines_n;
	logic [NUM_KW-1:0]  mask_q, mask_n;
	logic               fid_q, fid_n;

	logic [NUM_KW-1:0]  mask_upd, mask_first;
	logic [TYPE_W-1:0]  word_type, mtype, str_type;
	logic [LEN_W-1:0]   tb_inc;
	logic [LINE_W-1:0]  line_cur;
	logic               is_space, is_quote, is_digit, sfi;
	logic               a_v, b_v;
	tok_t               a_tok, b_tok;

	always_comb begin
		for (int k = 0; k < NUM_KW; k++) begin
			mask_upd[k] = mask_q[k] && (tb_q < LEN_W'(KW_LEN[k]))
				&& (kw_char(5'(k), tb_q[3:0]) == char_code);
			mask_first[k] = (kw_char(5'(k), 4'd0) == char_code);
		end
	end

	always_comb begin
		word_type = fid_q ? TOK_NUMBER : TOK_IDENT;
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			if (mask_q[k] && (LEN_W'(KW_LEN[k]) == tb_q))
				word_type = KW_TYPE[k];
		end
	end

	assign is_space = (char_code == 8'h20) || (char_code >= 8'h09 && char_code <= 8'h0D);
	assign is_quote = (char_code == 8'h22) || (char_code == 8'h27);
	assign is_digit = (char_code >= DIGIT_LO) && (char_code <= DIGIT_HI);
	assign mtype    = mark_type(char_code);
	assign str_type = qd_q ? TOK_STRING : TOK_CHAR;
	assign tb_inc   = (tb_q < LEN_MAX) ? tb_q + LEN_W'(1) : tb_q;
	assign line_cur = (lines_q == LINE_MAX) ? LINE_MAX : lines_q + LINE_W'(1);

	always_comb begin
		mode_n  = mode_q;
		qd_n    = qd_q;
		col_n   = col_q;
		start_n = start_q;
		tb_n    = tb_q;
		lines_n = lines_q;
		mask_n  = mask_q;
		fid_n   = fid_q;
		sfi     = 1'b0;
		a_v     = 1'b0;
		b_v     = 1'b0;
		a_tok   = '{token_type: word_type, line_number: line_cur, start_column: start_q,
			token_length: tb_q, last_of_run: 1'b0};
		b_tok   = '{token_type: mtype, line_number: line_cur, start_column: col_q,
			token_length: LEN_W'(1), last_of_run: 1'b0};
		if (func) begin
			unique case (mode_q)
				MODE_WORD: a_v = 1'b1;
				MODE_BANG: begin
					a_v = 1'b1;
					a_tok.token_type   = TOK_NOT;
					a_tok.token_length = LEN_W'(1);
				end
				MODE_QUOTE, MODE_ESC: begin
					a_v = 1'b1;
					a_tok.token_type = str_type;
				end
				default: a_v = 1'b0;
			endcase
			mode_n  = MODE_IDLE;
			col_n   = '0;
			lines_n = (lines_q == LINE_MAX) ? LINE_MAX : lines_q + LINE_W'(1);
		end else begin
			unique case (mode_q)
				MODE_BANG: begin
					mode_n = MODE_IDLE;
					a_v    = 1'b1;
					if (char_code == 8'h3D) begin
						a_tok.token_type   = TOK_NEQ;
						a_tok.token_length = LEN_W'(2);
					end else begin
						a_tok.token_type   = TOK_NOT;
						a_tok.token_length = LEN_W'(1);
						sfi = 1'b1;
					end
				end
				MODE_QUOTE: begin
					tb_n = tb_inc;
					if (char_code == 8'h5C) begin
						mode_n = MODE_ESC;
					end else if (char_code == (qd_q ? 8'h22 : 8'h27)) begin
						a_v    = 1'b1;
						a_tok.token_type   = str_type;
						a_tok.token_length = tb_inc;
						mode_n = MODE_IDLE;
					end
				end
				MODE_ESC: begin
					tb_n   = tb_inc;
					mode_n = MODE_QUOTE;
				end
				MODE_WORD: begin
					if (is_space || (mtype != TOK_NONE)) begin
						a_v    = 1'b1;
						mode_n = MODE_IDLE;
						sfi    = 1'b1;
					end else begin
						mask_n = mask_upd;
						tb_n   = tb_inc;
					end
				end
				default: begin
					mode_n = MODE_IDLE;
					sfi    = 1'b1;
				end
			endcase
			if (sfi && !is_space) begin
				if (mtype == TOK_NOT) begin
					mode_n  = MODE_BANG;
					start_n = col_q;
					tb_n    = LEN_W'(1);
				end else if (mtype != TOK_NONE) begin
					b_v = 1'b1;
				end else if (is_quote) begin
					mode_n  = MODE_QUOTE;
					qd_n    = (char_code == 8'h22);
					start_n = col_q;
					tb_n    = LEN_W'(1);
				end else begin
					mode_n  = MODE_WORD;
					start_n = col_q;
					tb_n    = LEN_W'(1);
					mask_n  = mask_first;
					fid_n   = is_digit;
				end
			end
			col_n = (col_q < COL_MAX) ? col_q + COL_W'(1) : col_q;
		end
	end

	always_comb begin
		toks = '0;
		if (accept) begin
			if (a_v) begin
				toks.v0 = 1'b1;
				toks.r0 = a_tok;
				toks.v1 = b_v;
				toks.r1 = b_tok;
				toks.r0.last_of_run = !b_v;
				toks.r1.last_of_run = 1'b1;
			end else if (b_v) begin
				toks.v0 = 1'b1;
				toks.r0 = b_tok;
				toks.r0.last_of_run = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			qd_q    <= 1'b0;
			col_q   <= '0;
			start_q <= '0;
			tb_q    <= '0;
			lines_q <= '0;
			mask_q  <= '1;
			fid_q   <= 1'b0;
		end else if (accept) begin
			mode_q  <= mode_n;
			qd_q    <= qd_n;
			col_q   <= col_n;
			start_q <= start_n;
			tb_q    <= tb_n;
			lines_q <= lines_n;
			mask_q  <= mask_n;
			fid_q   <= fid_n;
		end
	end

endmodule

// File: rtl/stl_outq.sv
`timescale 1ns / 1ps

module stl_outq import stl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  tok_pair_t toks,
	output logic      room,
	output logic      out_valid,
	input  logic      out_ready,
	output tok_t      out_tok
);

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	tok_t            ent_q [DEPTH];
	logic [PW-1:0]   head_q, tail_q;
	logic [PW:0]     count_q;
	logic            pop;
	logic [PW:0]     push_n;

	assign room      = (count_q <= (PW+1)'(DEPTH - 2));
	assign out_valid = (count_q != '0);
	assign out_tok   = ent_q[head_q];
	assign pop       = out_valid && out_ready;
	assign push_n    = (PW+1)'(toks.v0) + (PW+1)'(toks.v1);

	always_ff @(posedge clk) begin
		if (toks.v0)
			ent_q[tail_q] <= toks.r0;
		if (toks.v1)
			ent_q[tail_q + PW'(1)] <= toks.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + push_n[PW-1:0];
			count_q <= count_q + push_n - (PW+1)'(pop);
			if (pop)
				head_q <= head_q + PW'(1);
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PW+1)'(DEPTH))
		else $error("result queue overflow");
	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		toks.v0 |-> room)
		else $error("push without room");
	a_v1_after_v0: assert property (@(posedge clk) disable iff (!arst_n)
		toks.v1 |-> toks.v0)
		else $error("second result without first");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(toks.v1 && !pop) |=> count_q == $past(count_q) + (PW+1)'(2))
		else $error("count does not follow double push");
`endif

endmodule

// File: rtl/script_token_lexer.sv
`timescale 1ns / 1ps
// Script token lexer.
// Slave channel: one source byte per transfer. s_tdata[7:0] is the byte,
// s_tuser is 1 for the end-of-line marker (byte ignored then).
// Master channel: one token per transfer, fields packed from bit 0 up:
// token_type[5:0], line_number[25:6], start_column[37:26],
// token_length[50:38], zero fill [55:51]; m_tlast marks the last token
// caused by one input byte.
// A byte is taken every cycle while s_tready is high. Its tokens (zero, one
// or two) enter a four-entry result queue in the same clock edge and are
// offered on m_tvalid in queue order, behind any tokens already waiting.
// s_tready is high while the queue holds two or fewer tokens; the queue
// drains one token per cycle while m_tready is high, so sustained rate
// is one byte per cycle as long as bytes average at most one token.
// When m_tready is low the queue fills and s_tready drops; nothing is lost.
// Reset clears the scanner to between-tokens, column 0, line 1, and empties
// the queue.
module script_token_lexer import stl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code[7:0]
	input  logic        s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // token_type, line_number, start_column, token_length
	output logic        m_tlast
);

	tok_pair_t toks;
	tok_t      out_tok;
	logic      room;

	assign s_tready = room;

	stl_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (s_tvalid && room),
		.func      (s_tuser),
		.char_code (s_tdata),
		.toks      (toks)
	);

	stl_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.toks      (toks),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_tok   (out_tok)
	);

	assign m_tdata = {5'b0, out_tok.token_length, out_tok.start_column,
		out_tok.line_number, out_tok.token_type};
	assign m_tlast = out_tok.last_of_run;

endmodule

// File: tb/script_token_lexer_tb.sv
`timescale 1ns / 1ps

module script_token_lexer_tb;
	import stl_pkg::*;

	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_EOL  = 1'b1;

	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_DQ     = 8'h22;
	localparam logic [7:0] CH_SQ     = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam int RANDOM_ITEMS = 1500;
	localparam int HOLD_AT      = 120;
	localparam int LONG_HOLD    = 300;
	localparam int STALL_LIMIT  = 2000;

	typedef enum logic [TYPE_W-1:0] {
		TK_ADD, TK_SUB, TK_MUL, TK_DIV, TK_MOD, TK_EQUALS, TK_EQ, TK_NEQ,
		TK_LT, TK_GT, TK_LEQ, TK_GEQ, TK_OR, TK_AND, TK_IDENT, TK_STRING,
		TK_NUMBER, TK_SEMICOLON, TK_COLON, TK_LOOP, TK_IF, TK_NOT, TK_LET,
		TK_LBRACE, TK_RBRACE, TK_LPAREN, TK_RPAREN, TK_LBRACKET, TK_RBRACKET,
		TK_PUTS, TK_PUTV, TK_DEF, TK_RETURN, TK_STRUCT, TK_COMMA,
		TK_DOT, TK_TRUE, TK_FALSE, TK_GETC, TK_CHAR
	} tok_kind_e;

	typedef struct packed {
		bit         sync;
		bit         calm;
		logic       eol;
		logic [7:0] code;
	} src_item_t;

	string kw_word [NUM_KW] = '{
		"=", "==", "<", ">", "<=", ">=", "||", "&&", "+", "-", "*", "/", "%",
		"loop", "if", "let", string'({"print", "_str"}), string'({"print", "_val"}),
		"def", "return", "struct", "true", "false", string'({"read", "_char"})
	};
	logic [TYPE_W-1:0] kw_kind [NUM_KW] = '{
		TK_EQUALS, TK_EQ, TK_LT, TK_GT, TK_LEQ, TK_GEQ, TK_OR, TK_AND,
		TK_ADD, TK_SUB, TK_MUL, TK_DIV, TK_MOD, TK_LOOP, TK_IF, TK_LET,
		TK_PUTS, TK_PUTV, TK_DEF, TK_RETURN, TK_STRUCT, TK_TRUE,
		TK_FALSE, TK_GETC
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic        m_tlast;

	// lexer state as seen by the scoreboard
	mode_t             lx_mode;
	logic              lx_dq;
	logic [COL_W-1:0]  lx_col;
	logic [COL_W-1:0]  lx_start;
	logic [LEN_W-1:0]  lx_len;
	logic [LINE_W-1:0] lx_lines;
	logic [NUM_KW-1:0] kw_alive;
	logic              lx_digit;

	tok_t      tok_expected [$];
	src_item_t src_q [$];
	src_item_t next_src;
	tok_t      want;

	bit sync_next;
	bit calm_now;
	int tx_wait;
	int rx_wait;
	int quiet;
	int n_errors;
	int n_sent;
	int n_eol;
	int n_tokens;

	script_token_lexer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic bit punct_kind(input logic [7:0] c, output logic [TYPE_W-1:0] k);
		punct_kind = 1'b1;
		k = TK_NOT;
		case (c)
			";":     k = TK_SEMICOLON;
			":":     k = TK_COLON;
			"{":     k = TK_LBRACE;
			"}":     k = TK_RBRACE;
			"(":     k = TK_LPAREN;
			")":     k = TK_RPAREN;
			"[":     k = TK_LBRACKET;
			"]":     k = TK_RBRACKET;
			",":     k = TK_COMMA;
			".":     k = TK_DOT;
			CH_BANG: k = TK_NOT;
			default: punct_kind = 1'b0;
		endcase
	endfunction

	function automatic void grow_len();
		if (lx_len != LEN_MAX)
			lx_len++;
	endfunction

	function automatic void word_step(input logic [7:0] c);
		for (int k = 0; k < NUM_KW; k++)
			if (kw_alive[k] && !(lx_len < kw_word[k].len() && kw_word[k][lx_len] == c))
				kw_alive[k] = 1'b0;
		grow_len();
	endfunction

	function automatic logic [TYPE_W-1:0] word_kind();
		for (int k = 0; k < NUM_KW; k++)
			if (kw_alive[k] && kw_word[k].len() == lx_len)
				return kw_kind[k];
		return lx_digit ? TK_NUMBER : TK_IDENT;
	endfunction

	function automatic void push_token(input logic [TYPE_W-1:0] kind,
			input logic [COL_W-1:0] st, input logic [LEN_W-1:0] ln);
		tok_t t;
		t.token_type   = kind;
		t.line_number  = (lx_lines == LINE_MAX) ? LINE_MAX : lx_lines + 1'b1;
		t.start_column = st;
		t.token_length = ln;
		t.last_of_run  = 1'b0;
		tok_expected.push_back(t);
	endfunction

	function automatic void open_token(input logic [7:0] c, input logic [COL_W-1:0] col);
		logic [TYPE_W-1:0] k;
		bit is_mark;
		if (is_blank(c))
			return;
		is_mark = punct_kind(c, k);
		if (is_mark && k == TK_NOT) begin
			lx_mode = MODE_BANG;
			lx_start = col;
			lx_len = 1;
		end else if (is_mark) begin
			push_token(k, col, 1);
		end else if (c == CH_DQ || c == CH_SQ) begin
			lx_mode = MODE_QUOTE;
			lx_dq = (c == CH_DQ);
			lx_start = col;
			lx_len = 1;
		end else begin
			lx_mode = MODE_WORD;
			lx_start = col;
			lx_len = 0;
			kw_alive = '1;
			lx_digit = (c >= DIGIT_LO && c <= DIGIT_HI);
			word_step(c);
		end
	endfunction

	// advance the scoreboard by one accepted source transfer
	function automatic void predict_item(input logic eol, input logic [7:0] c);
		int n_before;
		logic [COL_W-1:0] col;
		logic [TYPE_W-1:0] k;
		bit is_mark;
		n_before = tok_expected.size();
		col = lx_col;
		if (eol == FUNC_EOL) begin
			case (lx_mode)
				MODE_WORD:  push_token(word_kind(), lx_start, lx_len);
				MODE_BANG:  push_token(TK_NOT, lx_start, 1);
				MODE_QUOTE,
				MODE_ESC:   push_token(lx_dq ? TK_STRING : TK_CHAR, lx_start, lx_len);
				default:    ;
			endcase
			lx_mode = MODE_IDLE;
			lx_col = '0;
			if (lx_lines != LINE_MAX)
				lx_lines++;
		end else begin
			case (lx_mode)
				MODE_BANG: begin
					lx_mode = MODE_IDLE;
					if (c == CH_EQ) begin
						push_token(TK_NEQ, lx_start, 2);
					end else begin
						push_token(TK_NOT, lx_start, 1);
						open_token(c, col);
					end
				end
				MODE_QUOTE: begin
					grow_len();
					if (c == CH_BSLASH) begin
						lx_mode = MODE_ESC;
					end else if (c == (lx_dq ? CH_DQ : CH_SQ)) begin
						push_token(lx_dq ? TK_STRING : TK_CHAR, lx_start, lx_len);
						lx_mode = MODE_IDLE;
					end
				end
				MODE_ESC: begin
					grow_len();
					lx_mode = MODE_QUOTE;
				end
				MODE_WORD: begin
					is_mark = punct_kind(c, k);
					if (is_blank(c) || is_mark) begin
						push_token(word_kind(), lx_start, lx_len);
						lx_mode = MODE_IDLE;
						open_token(c, col);
					end else begin
						word_step(c);
					end
				end
				default: begin
					lx_mode = MODE_IDLE;
					open_token(c, col);
				end
			endcase
			if (lx_col != COL_MAX)
				lx_col++;
		end
		if (tok_expected.size() > n_before)
			tok_expected[tok_expected.size() - 1].last_of_run = 1'b1;
	endfunction

	function automatic void check_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			n_errors++;
		end
	endfunction

	function automatic void put_item(input logic eol, input logic [7:0] code);
		src_item_t it;
		it.sync = sync_next;
		it.calm = calm_now;
		it.eol  = eol;
		it.code = code;
		sync_next = 1'b0;
		src_q.push_back(it);
	endfunction

	function automatic void put_byte(input logic [7:0] c);
		put_item(FUNC_BYTE, c);
	endfunction

	function automatic void put_eol();
		put_item(FUNC_EOL, 8'($urandom_range(0, 255)));
	endfunction

	function automatic void put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endfunction

	function automatic void put_random_token();
		string marks;
		logic [7:0] q;
		marks = ";:{}()[],.";
		case ($urandom_range(0, 10))
			0, 1: put_text(kw_word[$urandom_range(0, NUM_KW - 1)]);
			2: begin
				put_byte(8'($urandom_range(97, 122)));
				repeat ($urandom_range(0, 9))
					put_byte($urandom_range(0, 3) == 0 ? 8'($urandom_range(48, 57)) :
						8'($urandom_range(95, 122)));
			end
			3: repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(48, 57)));
			4: put_byte(marks[$urandom_range(0, 9)]);
			5: begin
				put_byte(CH_BANG);
				if ($urandom_range(0, 1))
					put_byte(CH_EQ);
			end
			6, 7: begin
				q = $urandom_range(0, 1) ? CH_DQ : CH_SQ;
				put_byte(q);
				repeat ($urandom_range(0, 6)) begin
					if ($urandom_range(0, 5) == 0) begin
						put_byte(CH_BSLASH);
						put_byte(8'($urandom_range(0, 255)));
					end else begin
						put_byte(8'($urandom_range(32, 126)));
					end
				end
				// some literals stay open until end of line
				if ($urandom_range(0, 7) != 0)
					put_byte(q);
			end
			8: repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)));
			default: begin
				put_text(kw_word[$urandom_range(0, NUM_KW - 1)]);
				put_byte(8'($urandom_range(97, 122)));
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= FUNC_BYTE;
			tx_wait = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_item(s_tuser, s_tdata);
				n_sent++;
				if (s_tuser == FUNC_EOL)
					n_eol++;
			end
			if (!s_tvalid || s_tready) begin
				if (tx_wait > 0) begin
					tx_wait--;
					s_tvalid <= 1'b0;
				end else if (src_q.size() != 0 &&
						!(src_q[0].sync && tok_expected.size() != 0)) begin
					next_src = src_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_src.code;
					s_tuser <= next_src.eol;
					tx_wait = next_src.calm ? 0 : $urandom_range(0, 6);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_tokens++;
				if (tok_expected.size() == 0) begin
					$error("unexpected token transfer: tdata=%h tlast=%b", m_tdata, m_tlast);
					n_errors++;
				end else begin
					want = tok_expected.pop_front();
					check_field("token_type", want.token_type, m_tdata[0 +: TYPE_W]);
					check_field("line_number", want.line_number, m_tdata[TYPE_W +: LINE_W]);
					check_field("start_column", want.start_column,
						m_tdata[TYPE_W + LINE_W +: COL_W]);
					check_field("token_length", want.token_length,
						m_tdata[TYPE_W + LINE_W + COL_W +: LEN_W]);
					check_field("last_of_run", want.last_of_run, m_tlast);
				end
				if (n_tokens == HOLD_AT)
					rx_wait = LONG_HOLD;
				else if ((n_tokens / 200) % 3 == 2)
					rx_wait = 0;
				else
					rx_wait = $urandom_range(0, 6);
			end
			if (rx_wait > 0) begin
				rx_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= STALL_LIMIT) begin
					$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
					$display("end of test: mismatches");
					$finish;
				end
			end
		end
	end

	initial begin
		int line_no;
		lx_mode = MODE_IDLE;
		lx_dq = 1'b0;
		lx_col = '0;
		lx_start = '0;
		lx_len = '0;
		lx_lines = '0;
		kw_alive = '1;
		lx_digit = 1'b0;
		sync_next = 1'b0;
		calm_now = 1'b0;
		quiet = 0;
		n_errors = 0;
		n_sent = 0;
		n_eol = 0;
		n_tokens = 0;

		// directed: byte extremes, marks ending words, bang forms, open literals
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(";");
		put_byte(CH_BANG);
		put_byte(CH_EQ);
		put_byte(CH_BANG);
		put_byte("(");
		put_text("7x");
		put_byte(CH_BANG);
		put_eol();
		put_eol();
		put_byte(CH_SQ);
		put_byte("a");
		put_byte(CH_BSLASH);
		put_eol();
		put_byte(CH_DQ);
		put_byte("q");
		put_byte(CH_BSLASH);
		put_byte(CH_DQ);
		put_byte(CH_DQ);
		put_text("if");
		put_byte(CH_SPACE);
		put_byte(CH_DQ);
		put_byte("z");
		put_eol();

		// random source lines
		line_no = 0;
		sync_next = 1'b1;
		while (src_q.size() < RANDOM_ITEMS) begin
			if (line_no % 16 == 15)
				sync_next = 1'b1;
			if (line_no % 10 == 0)
				calm_now = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 8)) begin
				case ($urandom_range(0, 3))
					0: ;
					1: put_byte(CH_SPACE);
					2: put_byte(8'h09);
					default: repeat ($urandom_range(1, 3))
						put_byte($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13)));
				endcase
				put_random_token();
			end
			put_eol();
			line_no++;
		end

		// bang pending at end of line, keyword alone on a line
		put_text("x;");
		put_byte(CH_BANG);
		put_eol();
		put_text("let");
		put_eol();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (src_q.size() != 0 || s_tvalid || tok_expected.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d source transfers (%0d end-of-line), %0d tokens checked",
			n_sent, n_eol, n_tokens);
		$display("incl. literals open at line end, output hold-off and drain pauses");
		if (n_errors == 0 && tok_expected.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
